// File: hdl/sm3_pkg.sv
package sm3_pkg;

  typedef logic [31:0] word_t;

  // Status of the compression core as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

  // Initial chaining value
  localparam word_t SM3_IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // Round constants for rounds 0..15 and 16..63
  localparam word_t T_LOW  = 32'h79CC4519;
  localparam word_t T_HIGH = 32'h7A879D8A;

  // Rounds in one compression
  localparam int ROUNDS = 64;

endpackage

// File: hdl/sm3_hash_engine.sv
// SM3 hash engine, one message word per beat, eight digest beats per message.
// A word is accepted only while idle; an aligned full word is stored whole,
// others byte by byte; each filled 64-byte block then runs through the
// one-round-per-cycle compression core. The end mark adds padding plus one
// or two compressions, then eight digest beats. Reset loads the initial
// value and clears both byte counts.
module sm3_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_ready,
  input  logic [31:0] msg_word,
  input  logic [2:0]  byte_count,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        digest_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BYTE = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_COMP = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]             state;
  logic [2:0]             ret;
  logic [31:0]            word;
  logic [2:0]             rem;
  logic                   last;
  logic [5:0]             fill;
  logic [63:0]            total;
  logic [3:0]             wp;
  logic                   extra;
  logic [2:0]             oi;
  logic                   start;
  logic [7:0][31:0]       cv;
  logic [7:0][31:0]       cv_new;
  logic [15:0][3:0][7:0]  blk;
  sm3_pkg::stat_t         stat;

  logic [3:0]             idx;
  logic [1:0]             lane;

  assign idx  = fill[5:2];
  assign lane = ~fill[1:0];

  sm3_round u_round (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .blk    (blk),
    .cv_in  (cv),
    .cv_out (cv_new),
    .stat   (stat)
  );

  assign msg_ready    = (state == S_IDLE);
  assign digest_valid = (state == S_OUT);
  assign digest_word  = cv[oi];
  assign digest_index = oi;
  assign digest_last  = (oi == 3'd7);

  // Control sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      fill  <= '0;
      total <= '0;
      oi    <= '0;
      start <= 1'b0;
      wp    <= '0;
      extra <= 1'b0;
      for (int k = 0; k < 8; k++) begin
        cv[k] <= sm3_pkg::SM3_IV[k];
      end
    end else begin
      start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (msg_valid) begin
            state <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (rem == 3'd0) begin
            state <= last ? S_PAD : S_IDLE;
          end else if (fill[1:0] == 2'd0 && rem == 3'd4) begin
            fill  <= fill + 6'd4;
            total <= total + 64'd4;
            if (idx == 4'd15) begin
              start <= 1'b1;
              ret   <= S_BYTE;
              state <= S_COMP;
            end
          end else begin
            fill  <= fill + 6'd1;
            total <= total + 64'd1;
            if (fill == 6'd63) begin
              start <= 1'b1;
              ret   <= S_BYTE;
              state <= S_COMP;
            end
          end
        end
        S_PAD: begin
          oi <= '0;
          if (idx == 4'd15) begin
            start <= 1'b1;
            ret   <= S_ZERO;
            wp    <= '0;
            extra <= 1'b0;
            state <= S_COMP;
          end else begin
            wp    <= idx + 4'd1;
            extra <= (idx >= 4'd14);
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (wp == 4'd14 && !extra) begin
            start <= 1'b1;
            ret   <= S_OUT;
            state <= S_COMP;
          end else if (wp == 4'd15) begin
            start <= 1'b1;
            ret   <= S_ZERO;
            wp    <= '0;
            extra <= 1'b0;
            state <= S_COMP;
          end else begin
            wp <= wp + 4'd1;
          end
        end
        S_COMP: begin
          if (stat.done) begin
            cv    <= cv_new;
            state <= ret;
          end
        end
        S_OUT: begin
          if (digest_ready) begin
            if (oi == 3'd7) begin
              for (int k = 0; k < 8; k++) begin
                cv[k] <= sm3_pkg::SM3_IV[k];
              end
              total <= '0;
              fill  <= '0;
              state <= S_IDLE;
            end else begin
              oi <= oi + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the accepted beat, shift out its bytes, fill and pad the block buffer
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (msg_valid) begin
          word <= msg_word;
          rem  <= (byte_count > 3'd4) ? 3'd4 : byte_count;
          last <= end_of_message;
        end
      end
      S_BYTE: begin
        if (rem == 3'd0) begin
          rem <= '0;
        end else if (fill[1:0] == 2'd0 && rem == 3'd4) begin
          blk[idx] <= word;
          rem      <= '0;
        end else begin
          blk[idx][lane] <= word[31:24];
          word           <= {word[23:0], 8'h00};
          rem            <= rem - 3'd1;
        end
      end
      S_PAD: begin
        // Drop the 0x80 marker in place and clear the rest of its word
        for (int l = 0; l < 4; l++) begin
          if (2'(l) == lane) begin
            blk[idx][l] <= 8'h80;
          end else if (2'(l) < lane) begin
            blk[idx][l] <= 8'h00;
          end
        end
      end
      S_ZERO: begin
        if (wp == 4'd14 && !extra) begin
          blk[14] <= total[60:29];
          blk[15] <= {total[28:0], 3'b000};
        end else begin
          blk[wp] <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && digest_valid))
    else $error("input and digest channels active together");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !stat.busy)
    else $error("compression started while core busy");

  a_done_in_comp: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == S_COMP))
    else $error("compression finished outside wait state");

  a_clear_after_digest: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && digest_last) |=>
      (fill == 6'd0 && total == 64'd0 && state == S_IDLE))
    else $error("counts not cleared after final digest beat");

endmodule

// File: hdl/sm3_round.sv
module sm3_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [15:0][31:0]   blk,
  input  logic [7:0][31:0]    cv_in,
  output logic [7:0][31:0]    cv_out,
  output sm3_pkg::stat_t      stat
);

  logic [15:0][31:0] w;
  logic [7:0][31:0]  r;
  logic [5:0]        rnd;
  logic              busy;
  logic              done;
  sm3_pkg::word_t    tj;

  sm3_pkg::word_t    a12, ss1, ss2, ff, gg, tt1, tt2, wx, pre;

  function automatic sm3_pkg::word_t rol(input sm3_pkg::word_t x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  function automatic sm3_pkg::word_t p0(input sm3_pkg::word_t x);
    p0 = x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic sm3_pkg::word_t p1(input sm3_pkg::word_t x);
    p1 = x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  // One round of the compression function, plus one step of word expansion
  always_comb begin
    a12 = rol(r[0], 12);
    ss1 = rol(a12 + r[4] + tj, 7);
    ss2 = ss1 ^ a12;
    if (rnd < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + (w[0] ^ w[4]);
    tt2 = gg + r[7] + ss1 + w[0];
    pre = w[0] ^ w[7] ^ rol(w[13], 15);
    wx  = p1(pre) ^ rol(w[3], 7) ^ w[10];
  end

  // Sequence the 64 rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'(sm3_pkg::ROUNDS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load the block and chaining value, then advance the working registers
  always_ff @(posedge clk) begin
    if (start) begin
      w  <= blk;
      r  <= cv_in;
      tj <= sm3_pkg::T_LOW;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= wx;
      r[3] <= r[2];
      r[2] <= rol(r[1], 9);
      r[1] <= r[0];
      r[0] <= tt1;
      r[7] <= r[6];
      r[6] <= rol(r[5], 19);
      r[5] <= r[4];
      r[4] <= p0(tt2);
      // Rotate the round constant one bit per round; switch at round 16
      if (rnd == 6'd15) begin
        tj <= rol(sm3_pkg::T_HIGH, 16);
      end else begin
        tj <= rol(tj, 1);
      end
    end
  end

  assign cv_out      = cv_in ^ r;
  assign stat.busy   = busy;
  assign stat.done   = done;

endmodule
